// ----- rtl/rhsv_pkg.sv -----
package rhsv_pkg;

    // One pixel, three 8-bit channels.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Per-pixel values that travel alongside the channels down the pipe.
    typedef struct packed {
        logic       grey;
        logic [7:0] desat;
        logic [7:0] sat;
        logic [7:0] vidx;
    } t_side;

    typedef logic [7:0] t_lut8 [256];

    // Floor of sqrt(d * 256), one result bit per step.
    function automatic logic [7:0] f_isqrt8(input logic [7:0] d);
        logic [15:0] x;
        logic [7:0]  root;
        logic [7:0]  trial;
        int          k;
        x    = {d, 8'h00};
        root = '0;
        for (k = 7; k >= 0; k--) begin
            trial = root | (8'd1 << k);
            if (16'(trial) * 16'(trial) <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_lut8 f_sqrt_lut();
        t_lut8 lut;
        int    i;
        for (i = 0; i < 256; i++) begin
            lut[i] = f_isqrt8(8'(i));
        end
        return lut;
    endfunction

    // Square-root table used to un-dim saturation and value.
    localparam t_lut8 SQRT_LUT = f_sqrt_lut();

endpackage

// ----- rtl/rhsv_rgb_if.sv -----
interface rhsv_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

// ----- rtl/rhsv_hsv_if.sv -----
interface rhsv_hsv_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue_out;
    logic [7:0] sat_out;
    logic [7:0] val_out;

    modport source (output valid, output hue_out, output sat_out, output val_out,
                    input ready);
    modport sink   (input valid, input hue_out, input sat_out, input val_out,
                    output ready);
endinterface

// ----- rtl/rhsv_rescale.sv -----
module rhsv_rescale import rhsv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_rgb       i_rgb,
    input  t_side      i_side,
    input  logic [7:0] i_div,
    input  logic       i_en,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rgb       o_rgb,
    output t_side      o_side
);

    // Reciprocal table: 65535 / divisor, with a zero divisor taken as one.
    logic [15:0] w_recip [256];

    for (genvar k = 0; k < 256; k++) begin : g_recip
        localparam int unsigned Div = (k == 0) ? 1 : k;
        localparam logic [15:0] Recip = 16'(65535 / Div);
        assign w_recip[k] = Recip;
    end

    logic        r_a_vld;
    t_rgb        r_a_rgb;
    t_side       r_a_side;
    logic [15:0] r_a_factor;
    logic        r_a_en;
    logic        r_b_vld;
    t_rgb        r_b_rgb;
    t_side       r_b_side;
    logic        w_a_rdy;
    logic        w_b_rdy;
    t_rgb        n_b_rgb;
    logic [23:0] w_pr;
    logic [23:0] w_pg;
    logic [23:0] w_pb;

    assign w_b_rdy = !r_b_vld || i_ready;
    assign w_a_rdy = !r_a_vld || w_b_rdy;
    assign o_ready = w_a_rdy;

    // Stage A: look up the factor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_a_rdy) begin
            r_a_vld <= i_valid;
        end
        if (w_a_rdy && i_valid) begin
            r_a_rgb    <= i_rgb;
            r_a_side   <= i_side;
            r_a_factor <= w_recip[i_div];
            r_a_en     <= i_en;
        end
    end

    // Stage B: multiply each channel and keep bits 15:8, or pass it through when disabled.
    always_comb begin
        w_pr    = 24'(r_a_rgb.r) * 24'(r_a_factor);
        w_pg    = 24'(r_a_rgb.g) * 24'(r_a_factor);
        w_pb    = 24'(r_a_rgb.b) * 24'(r_a_factor);
        n_b_rgb = r_a_rgb;
        if (r_a_en) begin
            n_b_rgb.r = w_pr[15:8];
            n_b_rgb.g = w_pg[15:8];
            n_b_rgb.b = w_pb[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_b_rdy) begin
            r_b_vld <= r_a_vld;
        end
        if (w_b_rdy && r_a_vld) begin
            r_b_rgb  <= n_b_rgb;
            r_b_side <= r_a_side;
        end
    end

    assign o_valid = r_b_vld;
    assign o_rgb   = r_b_rgb;
    assign o_side  = r_b_side;

endmodule

// ----- rtl/rhsv_hue.sv -----
module rhsv_hue import rhsv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_rgb       i_rgb,
    input  t_side      i_side,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_hue,
    output logic [7:0] o_sat,
    output logic [7:0] o_val
);

    localparam logic [7:0] HUE_CYAN = 8'd128;
    localparam logic [7:0] HUE_NAVY = 8'd160;

    function automatic logic [7:0] f_scale8(input logic [7:0] v, input logic [7:0] s);
        logic [15:0] p;
        p = 16'(v) * (16'(s) + 16'd1);
        return p[15:8];
    endfunction

    function automatic logic [7:0] f_qsub8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

    logic       r_vld;
    logic [7:0] r_hue;
    logic [7:0] r_sat;
    logic [7:0] r_val;
    logic       w_rdy;
    logic [7:0] w_h;
    logic [7:0] w_radj;
    logic [7:0] w_gadj;
    logic [7:0] w_gsum;
    logic [7:0] w_rwrap;
    logic [7:0] n_hue;
    logic [7:0] n_sat;
    logic [7:0] n_val;

    assign w_rdy   = !r_vld || i_ready;
    assign o_ready = w_rdy;

    always_comb begin
        w_radj  = f_scale8(f_qsub8(8'd171, i_rgb.r), 8'd47);
        w_gadj  = f_scale8(f_qsub8(i_rgb.g, 8'd171), 8'd96);
        w_gsum  = w_radj + w_gadj;
        w_rwrap = i_rgb.g + 8'd86 - i_rgb.r;
        // The dominant channel picks the wheel segment; ties go to red, then green.
        priority if (i_rgb.r >= i_rgb.g && i_rgb.r >= i_rgb.b) begin
            priority if (i_rgb.g == 8'd0) begin
                w_h = 8'd208 + f_scale8(f_qsub8(i_rgb.r, 8'd128), 8'd96);
            end else if (8'(i_rgb.r - i_rgb.g) > i_rgb.g) begin
                w_h = f_scale8(i_rgb.g, 8'd96);
            end else begin
                w_h = 8'd32 + f_scale8(f_qsub8(w_rwrap, 8'd4), 8'd96);
            end
        end else if (i_rgb.g >= i_rgb.b) begin
            priority if (i_rgb.b == 8'd0) begin
                w_h = 8'd64 + (w_gsum >> 1);
            end else if (8'(i_rgb.g - i_rgb.b) > i_rgb.b) begin
                w_h = 8'd96 + f_scale8(i_rgb.b, 8'd96);
            end else begin
                w_h = HUE_CYAN + f_scale8(f_qsub8(i_rgb.b, 8'd85), 8'd48);
            end
        end else begin
            priority if (i_rgb.r == 8'd0) begin
                w_h = HUE_CYAN + ((HUE_NAVY - HUE_CYAN) >> 2)
                    + f_scale8(f_qsub8(i_rgb.b, 8'd128), 8'd48);
            end else if (8'(i_rgb.b - i_rgb.r) > i_rgb.r) begin
                w_h = HUE_NAVY + f_scale8(i_rgb.r, 8'd96);
            end else begin
                w_h = 8'd192 + f_scale8(f_qsub8(i_rgb.r, 8'd85), 8'd96);
            end
        end

        n_val = SQRT_LUT[i_side.vidx];
        if (i_side.grey) begin
            n_hue = 8'd0;
            n_sat = 8'd0;
        end else begin
            n_hue = w_h + 8'd1;
            n_sat = i_side.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_valid;
        end
        if (w_rdy && i_valid) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= n_val;
        end
    end

    assign o_valid = r_vld;
    assign o_hue   = r_hue;
    assign o_sat   = r_sat;
    assign o_val   = r_val;

endmodule

// ----- rtl/rgb_to_hsv_approximate.sv -----
// Channel   Dir   Signals                               Item
// i_pix     in    valid, ready, red_in/green_in/blue_in  one RGB pixel, 8 bits each
// o_hsv     out   valid, ready, hue_out/sat_out/val_out  one HSV result, 8 bits each
//
// One pixel enters per clock while no stage is stalled; each result passes
// through the eight register stages of the pipe on its way out.
// Reset (i_rst_n low at a rising edge) clears every stage valid bit; no table
// needs filling, so the block can take a pixel as soon as reset is released.
// Each stage holds its item while the next one is full and cannot move on, so a
// stall at the output backs up only through full stages and bubbles are still filled.
module rgb_to_hsv_approximate import rhsv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhsv_rgb_if.sink   i_pix,
    rhsv_hsv_if.source o_hsv
);

    // Stage 1: find the smallest channel and remove it from all three.
    logic       r_s1_vld;
    t_rgb       r_s1_rgb;
    logic [7:0] r_s1_desat;
    logic       w_s1_rdy;
    logic [7:0] w_min_rg;
    logic [7:0] n_s1_desat;

    // Stage 2: un-dim the saturation through the square-root table.
    logic       r_s2_vld;
    t_rgb       r_s2_rgb;
    t_side      r_s2_side;
    logic       r_s2_en;
    logic       w_s2_rdy;
    logic [7:0] w_s2_sat;
    t_side      n_s2_side;

    // First rescale, by 65535 / saturation.
    logic       w_r1_vld;
    logic       w_r1_rdy;
    t_rgb       w_r1_rgb;
    t_side      w_r1_side;

    // Stage 4: total of the rescaled channels and the value index.
    logic       r_s4_vld;
    t_rgb       r_s4_rgb;
    t_side      r_s4_side;
    logic [7:0] r_s4_div;
    logic       r_s4_en;
    logic       w_s4_rdy;
    logic [9:0] w_sum;
    logic [9:0] w_total;
    logic [9:0] w_vsum;
    t_side      n_s4_side;

    // Second rescale, by 65535 / total, then hue and output register.
    logic       w_r2_vld;
    logic       w_r2_rdy;
    t_rgb       w_r2_rgb;
    t_side      w_r2_side;
    logic       w_hue_rdy;

    // Each stage can take a new item when it is empty or its item moves on.
    assign w_s4_rdy    = !r_s4_vld || w_r2_rdy;
    assign w_s2_rdy    = !r_s2_vld || w_r1_rdy;
    assign w_s1_rdy    = !r_s1_vld || w_s2_rdy;
    assign i_pix.ready = w_s1_rdy;

    always_comb begin
        w_min_rg   = (i_pix.green_in < i_pix.red_in) ? i_pix.green_in : i_pix.red_in;
        n_s1_desat = (i_pix.blue_in < w_min_rg) ? i_pix.blue_in : w_min_rg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_s1_rdy) begin
            r_s1_vld <= i_pix.valid;
        end
        if (w_s1_rdy && i_pix.valid) begin
            r_s1_rgb.r <= i_pix.red_in - n_s1_desat;
            r_s1_rgb.g <= i_pix.green_in - n_s1_desat;
            r_s1_rgb.b <= i_pix.blue_in - n_s1_desat;
            r_s1_desat <= n_s1_desat;
        end
    end

    // A saturation of zero would need a divide by zero; it is forced to one.
    // It cannot occur for a pixel with any color, so the clamp is only a guard.
    always_comb begin
        w_s2_sat        = 8'd255 - SQRT_LUT[r_s1_desat];
        n_s2_side.grey  = (r_s1_rgb.r == 8'd0) && (r_s1_rgb.g == 8'd0)
                        && (r_s1_rgb.b == 8'd0);
        n_s2_side.desat = r_s1_desat;
        n_s2_side.sat   = (w_s2_sat == 8'd0) ? 8'd1 : w_s2_sat;
        n_s2_side.vidx  = 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_s2_rdy) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_s2_rdy && r_s1_vld) begin
            r_s2_rgb  <= r_s1_rgb;
            r_s2_side <= n_s2_side;
            r_s2_en   <= (n_s2_side.sat != 8'd255);
        end
    end

    rhsv_rescale u_rescale_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_vld),
        .o_ready (w_r1_rdy),
        .i_rgb   (r_s2_rgb),
        .i_side  (r_s2_side),
        .i_div   (r_s2_side.sat),
        .i_en    (r_s2_en),
        .o_valid (w_r1_vld),
        .i_ready (w_s4_rdy),
        .o_rgb   (w_r1_rgb),
        .o_side  (w_r1_side)
    );

    // A total of zero is taken as one. Value is the un-dimmed, saturated sum
    // of the removed grey and the total; grey pixels use the grey level alone.
    always_comb begin
        w_sum     = 10'(w_r1_rgb.r) + 10'(w_r1_rgb.g) + 10'(w_r1_rgb.b);
        w_total   = (w_sum == 10'd0) ? 10'd1 : w_sum;
        w_vsum    = 10'(w_r1_side.desat) + w_total;
        n_s4_side = w_r1_side;
        if (w_r1_side.grey) begin
            n_s4_side.vidx = w_r1_side.desat;
        end else begin
            n_s4_side.vidx = (w_vsum > 10'd255) ? 8'd255 : w_vsum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_s4_rdy) begin
            r_s4_vld <= w_r1_vld;
        end
        if (w_s4_rdy && w_r1_vld) begin
            r_s4_rgb  <= w_r1_rgb;
            r_s4_side <= n_s4_side;
            r_s4_div  <= w_total[7:0];
            r_s4_en   <= (w_sum < 10'd255);
        end
    end

    rhsv_rescale u_rescale_total (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_vld),
        .o_ready (w_r2_rdy),
        .i_rgb   (r_s4_rgb),
        .i_side  (r_s4_side),
        .i_div   (r_s4_div),
        .i_en    (r_s4_en),
        .o_valid (w_r2_vld),
        .i_ready (w_hue_rdy),
        .o_rgb   (w_r2_rgb),
        .o_side  (w_r2_side)
    );

    rhsv_hue u_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_r2_vld),
        .o_ready (w_hue_rdy),
        .i_rgb   (w_r2_rgb),
        .i_side  (w_r2_side),
        .o_valid (o_hsv.valid),
        .i_ready (o_hsv.ready),
        .o_hue   (o_hsv.hue_out),
        .o_sat   (o_hsv.sat_out),
        .o_val   (o_hsv.val_out)
    );

    // An open output leaves no stage blocked, so the input must be open too.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.ready |-> i_pix.ready)
        else $error("input blocked while the output is ready");

    // Only grey pixels report zero saturation, and they carry hue zero.
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hsv.valid && o_hsv.sat_out == 8'd0) |-> (o_hsv.hue_out == 8'd0))
        else $error("zero saturation with nonzero hue");

    // The value index is a saturating sum and never drops below the grey level.
    a_vidx_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_s4_side.vidx >= r_s4_side.desat))
        else $error("value index below the removed grey level");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import rhsv_pkg::*;

    // Result of one pixel as the block should report it.
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } t_hsv_px;

    localparam int IDLE_PCT        = 19;    // percent of cycles each side idles
    localparam int STALL_LIMIT     = 4000;  // cycles with no transfer before giving up
    localparam int TAIL_CYCLES     = 24;    // pipe is eight deep, wait well past it
    localparam int ROOT_WIDE_LIMIT = 7904;  // above this the root search reaches up to 255
    localparam int HUE_CYAN        = 128;
    localparam int HUE_NAVY        = 160;
    localparam int SEG_GREY        = 0;     // hue segments are 1 to 8, grey is 0

    logic clk;
    logic rst_n;

    rhsv_rgb_if pix();
    rhsv_hsv_if hsv();

    rgb_to_hsv_approximate dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix),
        .o_hsv   (hsv)
    );

    // Results still owed by the block, oldest first.
    t_hsv_px     hsv_expected[$];
    t_hsv_px     hsv_head;
    int          errors       = 0;
    int          pixels_sent  = 0;
    int          grey_pixels  = 0;
    int          drain_pauses = 0;
    int          idle_run     = 0;
    logic [8:0]  segments_hit = '0;
    // While set, neither side idles: the pipe should run at one pixel per clock.
    logic        steady_flow  = 1'b0;

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // Integer square root of a 16-bit word by binary search. The search
    // window is narrow for small words and opens fully above the wide limit;
    // a hit on 255 ends the search at once.
    function automatic logic [7:0] root_of_word(input int unsigned x);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        x = x & 32'hFFFF;
        if (x <= 1) begin
            return 8'(x);
        end
        lo = 1;
        hi = (x > ROOT_WIDE_LIMIT) ? 255 : (x >> 5) + 8;
        do begin
            mid = (lo + hi) >> 1;
            if (mid * mid > x) begin
                hi = mid - 1;
            end else begin
                if (mid == 255) begin
                    return 8'd255;
                end
                lo = mid + 1;
            end
        end while (hi >= lo);
        return 8'(lo - 1);
    endfunction

    // Scale an 8-bit value by (scale + 1) / 256.
    function automatic int unsigned frac_scale(input int unsigned i, input int unsigned scale);
        return ((i & 255) * (1 + (scale & 255))) >> 8;
    endfunction

    // Subtraction that stops at zero.
    function automatic int unsigned floor_sub(input int unsigned i, input int unsigned j);
        return (i > j) ? i - j : 0;
    endfunction

    // Expected hue, saturation and value of one pixel. The wheel segment
    // that produced the hue is handed back so the run can report which
    // segments it reached.
    function automatic t_hsv_px hsv_of_pixel(input t_rgb px, output int segment);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned desat;
        int unsigned s;
        int unsigned v;
        int unsigned h;
        int unsigned total;
        int unsigned boost;
        int unsigned top;
        int unsigned radj;
        int unsigned gadj;
        t_hsv_px     res;
        r = px.r;
        g = px.g;
        b = px.b;

        // The smallest channel is the white part of the pixel.
        desat = r;
        if (g < desat) desat = g;
        if (b < desat) desat = b;
        r = r - desat;
        g = g - desat;
        b = b - desat;

        s = 255 - desat;
        if (s != 255) begin
            s = 255 - root_of_word(desat << 8);
        end

        // Grey: no hue, no saturation, value from the un-dimmed saturation.
        if (r + g + b == 0) begin
            segment = SEG_GREY;
            res.hue = 8'd0;
            res.sat = 8'd0;
            res.val = 8'((255 - s) & 255);
            return res;
        end

        // Stretch the colored part back out by the saturation. Channels
        // wrap at eight bits, so a stretched channel can land on zero.
        if (s < 255) begin
            if (s == 0) s = 1;
            boost = 65535 / s;
            r = ((r * boost) >> 8) & 255;
            g = ((g * boost) >> 8) & 255;
            b = ((b * boost) >> 8) & 255;
        end

        // Then normalize the channels to their total.
        total = r + g + b;
        if (total < 255) begin
            if (total == 0) total = 1;
            boost = 65535 / total;
            r = ((r * boost) >> 8) & 255;
            g = ((g * boost) >> 8) & 255;
            b = ((b * boost) >> 8) & 255;
        end

        if (total > 255) begin
            v = 255;
        end else begin
            v = desat + total;
            if (v > 255) v = 255;
            if (v != 255) v = root_of_word(v << 8);
        end

        top = r;
        if (g > top) top = g;
        if (b > top) top = b;

        // Eight wheel segments, segment 8 from two branches, picked by the
        // dominant channel and how the channel after it (r->g->b->r) compares with it.
        if (top == r) begin
            if (g == 0) begin
                segment = 1;
                h = 208 + frac_scale(floor_sub(r, 128), 96);
            end else if (r - g > g) begin
                segment = 2;
                h = frac_scale(g, 96);
            end else begin
                segment = 3;
                h = 32 + frac_scale(floor_sub((g + 86 - r) & 255, 4), 96);
            end
        end else if (top == g) begin
            if (b == 0) begin
                segment = 4;
                radj = frac_scale(floor_sub(171, r), 47);
                gadj = frac_scale(floor_sub(g, 171), 96);
                h = 64 + (((radj + gadj) & 255) >> 1);
            end else if (g - b > b) begin
                segment = 5;
                h = 96 + frac_scale(b, 96);
            end else begin
                segment = 6;
                h = HUE_CYAN + frac_scale(floor_sub(b, 85), 48);
            end
        end else begin
            if (r == 0) begin
                segment = 7;
                h = HUE_CYAN + ((HUE_NAVY - HUE_CYAN) >> 2) + frac_scale(floor_sub(b, 128), 48);
            end else if (b - r > r) begin
                segment = 8;
                h = HUE_NAVY + frac_scale(r, 96);
            end else begin
                segment = 8;
                h = 192 + frac_scale(floor_sub(r, 85), 96);
            end
        end

        res.hue = 8'((h + 1) & 255);
        res.sat = 8'(s & 255);
        res.val = 8'(v & 255);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Pixel side.
    // ------------------------------------------------------------------

    // Offer one pixel, with a random gap first unless the flow is steady,
    // and record its expected result once the block has taken it. Valid
    // stays high afterwards so back-to-back pixels follow without a gap.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        t_rgb    px;
        t_hsv_px want;
        int      segment;
        px = '{r: r, g: g, b: b};
        if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                pix.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix.valid    <= 1'b1;
        pix.red_in   <= r;
        pix.green_in <= g;
        pix.blue_in  <= b;
        @(posedge clk);
        while (!pix.ready) begin
            @(posedge clk);
        end
        want = hsv_of_pixel(px, segment);
        hsv_expected.push_back(want);
        segments_hit[segment] = 1'b1;
        pixels_sent++;
        if (segment == SEG_GREY) grey_pixels++;
    endtask

    // Stop offering pixels and hold until every owed result has come back.
    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (hsv_expected.size() != 0) begin
            @(posedge clk);
        end
        drain_pauses++;
    endtask

    // A random pixel from a mix of shapes: plain noise, exact greys,
    // near-greys, pixels with one channel at zero, and channel extremes.
    task automatic random_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
        logic [7:0] corner_vals[6];
        logic [7:0] base;
        int         pick;
        corner_vals = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        pick = $urandom_range(99);
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        if (pick < 10) begin
            r = g;
            b = g;
        end else if (pick < 30) begin
            base = 8'($urandom_range(255));
            r = base ^ 8'($urandom_range(3));
            g = base ^ 8'($urandom_range(3));
            b = base ^ 8'($urandom_range(3));
        end else if (pick < 50) begin
            case ($urandom_range(2))
                0: begin
                    r = 8'd0;
                    if ($urandom_range(1) == 0) g = 8'd255;
                end
                1: begin
                    g = 8'd0;
                    if ($urandom_range(1) == 0) b = 8'd255;
                end
                default: begin
                    b = 8'd0;
                    if ($urandom_range(1) == 0) r = 8'd255;
                end
            endcase
        end else if (pick < 60) begin
            r = corner_vals[$urandom_range(5)];
            g = corner_vals[$urandom_range(5)];
            b = corner_vals[$urandom_range(5)];
        end
    endtask

    // ------------------------------------------------------------------
    // Result side.
    // ------------------------------------------------------------------

    // The receiver refuses results now and then, except in the steady phase.
    always @(posedge clk) begin
        if (!rst_n) begin
            hsv.ready <= 1'b0;
        end else if (steady_flow) begin
            hsv.ready <= 1'b1;
        end else begin
            hsv.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every result taken is compared field by field with the oldest one owed.
    always @(posedge clk) begin
        if (rst_n && hsv.valid === 1'b1 && hsv.ready === 1'b1) begin
            if (hsv_expected.size() == 0) begin
                errors++;
                $display("%0t: result with no pixel pending: hue %0d sat %0d val %0d",
                         $time, hsv.hue_out, hsv.sat_out, hsv.val_out);
            end else begin
                hsv_head = hsv_expected.pop_front();
                if (hsv.hue_out !== hsv_head.hue) begin
                    errors++;
                    $display("%0t: hue mismatch: expected %0d, got %0d",
                             $time, hsv_head.hue, hsv.hue_out);
                end
                if (hsv.sat_out !== hsv_head.sat) begin
                    errors++;
                    $display("%0t: saturation mismatch: expected %0d, got %0d",
                             $time, hsv_head.sat, hsv.sat_out);
                end
                if (hsv.val_out !== hsv_head.val) begin
                    errors++;
                    $display("%0t: value mismatch: expected %0d, got %0d",
                             $time, hsv_head.val, hsv.val_out);
                end
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means
    // the block has hung.
    always @(posedge clk) begin
        if ((pix.valid && pix.ready) || (hsv.valid && hsv.ready) || !rst_n) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results still owed",
                     $time, idle_run, hsv_expected.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Greys from black to white; value must follow the square root.
    task automatic test_grey_levels();
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd254, 8'd254, 8'd254);
        send_pixel(8'd255, 8'd255, 8'd255);
    endtask

    // Each of the eight wheel segments, plus ties for the dominant channel.
    task automatic test_hue_segments();
        send_pixel(8'd255, 8'd0,   8'd0);    // red, no green
        send_pixel(8'd130, 8'd0,   8'd40);   // red leaning to magenta
        send_pixel(8'd255, 8'd100, 8'd0);    // red toward orange
        send_pixel(8'd255, 8'd200, 8'd0);    // orange toward yellow
        send_pixel(8'd0,   8'd255, 8'd0);    // pure green
        send_pixel(8'd0,   8'd255, 8'd100);  // green toward aqua
        send_pixel(8'd0,   8'd255, 8'd200);  // aqua
        send_pixel(8'd0,   8'd0,   8'd255);  // pure blue
        send_pixel(8'd0,   8'd100, 8'd255);  // blue toward aqua
        send_pixel(8'd100, 8'd0,   8'd255);  // blue toward purple
        send_pixel(8'd200, 8'd0,   8'd255);  // purple
        send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
        send_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
        send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie
    endtask

    // Corners of the two rescale steps.
    task automatic test_rescale_corners();
        // Stretching by the saturation wraps red to zero, so the total
        // is zero and gets forced to one.
        send_pixel(8'd228, 8'd4,   8'd4);
        // Largest white part that still leaves a color.
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd255);
        // Smallest color on black, and a total well over 255.
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd128, 8'd64);
    endtask

    // Random pixels back to back with the output always ready: the pipe
    // must sustain one pixel per clock.
    task automatic test_steady_stream(input int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         n;
        steady_flow = 1'b1;
        for (n = 0; n < count; n++) begin
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
        steady_flow = 1'b0;
    endtask

    // Random pixels with random gaps and stalls on both sides. Once halfway
    // through, and now and then at random, the sender waits for the pipe to
    // empty before going on.
    task automatic test_random_pixels(input int count);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         n;
        for (n = 0; n < count; n++) begin
            if (n == count / 2 || $urandom_range(299) == 0) begin
                wait_drained();
            end
            random_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        rst_n        <= 1'b0;
        pix.valid    <= 1'b0;
        pix.red_in   <= 8'd0;
        pix.green_in <= 8'd0;
        pix.blue_in  <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_grey_levels();
        test_hue_segments();
        test_rescale_corners();
        test_steady_stream(300);
        test_random_pixels(1100);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d pixels converted, %0d of them grey, %0d of 8 hue segments hit",
                 pixels_sent, grey_pixels, $countones(segments_hit) - segments_hit[SEG_GREY]);
        $display("tb_top: steady stream and random gaps run, pipe emptied %0d times mid-run",
                 drain_pauses - 1);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rhsv_pkg.sv
rtl/rhsv_rgb_if.sv
rtl/rhsv_hsv_if.sv
rtl/rhsv_rescale.sv
rtl/rhsv_hue.sv
rtl/rgb_to_hsv_approximate.sv
bench/tb_top.sv
